/* hdl/lph_pkg.sv */
package lph_pkg;

  // Table geometry
  localparam int TABLE_SLOTS = 16;
  localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

  // Field widths
  localparam int KEY_W        = 31;
  localparam int STATUS_W     = 2;
  localparam int SLOT_FIELD_W = 4;

  // Home slot reduction: a mask for a power-of-two table, else a digit-serial
  // remainder, MOD_DIGIT_W key bits per cycle, MSB first
  localparam bit SLOTS_POW2  = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
  localparam int MOD_DIGIT_W = 4;
  localparam int MOD_STEPS   = (KEY_W + MOD_DIGIT_W - 1) / MOD_DIGIT_W;
  localparam int MOD_BITS    = MOD_STEPS * MOD_DIGIT_W;
  localparam int MOD_CNT_W   = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

  // Request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [KEY_W-1:0]  key_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // One classified request: operation, key and its home slot
  typedef struct packed {
    op_t   op;
    key_t  key;
    slot_t home;
  } probe_req_t;

  // Linear probe step with wraparound
  function automatic slot_t next_slot(input slot_t s);
    slot_t n;
    if (s == SLOT_W'(TABLE_SLOTS - 1)) n = '0;
    else                              n = s + 1'b1;
    return n;
  endfunction

endpackage

/* hdl/lph_ram.sv */
module lph_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/lph_front.sv */
module lph_front import lph_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_opcode,
  input  key_t       in_key,
  output logic       req_valid,
  input  logic       req_ready,
  output probe_req_t req
);

  logic                busy_r;
  logic                done_r;
  logic [MOD_CNT_W-1:0] cnt_r;
  op_t                 op_r;
  key_t                key_r;
  logic [MOD_BITS-1:0] digits_r;
  slot_t               rem_r;

  logic                in_acc;
  logic                push;
  logic [SLOT_W:0]     part;
  slot_t               rem_step;

  assign push     = busy_r && done_r && req_ready;
  assign in_ready = !busy_r || push;
  assign in_acc   = in_valid && in_ready;

  // Remainder by table size: shift in one digit per cycle, trial subtract per bit
  always_comb begin
    part = {1'b0, rem_r};
    for (int i = 0; i < MOD_DIGIT_W; i++) begin
      part = {part[SLOT_W-1:0], digits_r[MOD_BITS-1-i]};
      if (part >= (SLOT_W+1)'(TABLE_SLOTS)) begin
        part = part - (SLOT_W+1)'(TABLE_SLOTS);
      end
    end
    rem_step = part[SLOT_W-1:0];
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (in_acc) begin
      busy_r <= 1'b1;
      done_r <= SLOTS_POW2;
      cnt_r  <= '0;
    end else if (push) begin
      busy_r <= 1'b0;
    end else if (busy_r && !done_r) begin
      cnt_r  <= cnt_r + 1'b1;
      done_r <= (cnt_r == MOD_CNT_W'(MOD_STEPS - 1));
    end
  end

  // Beat payload and remainder datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r     <= op_t'(in_opcode);
      key_r    <= in_key;
      digits_r <= MOD_BITS'(in_key);
      rem_r    <= SLOTS_POW2 ? in_key[SLOT_W-1:0] : '0;
    end else if (busy_r && !done_r) begin
      rem_r    <= rem_step;
      digits_r <= digits_r << MOD_DIGIT_W;
    end
  end

  assign req_valid = busy_r && done_r;
  assign req.op    = op_r;
  assign req.key   = key_r;
  assign req.home  = rem_r;

endmodule

/* hdl/lph_queue.sv */
module lph_queue import lph_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  probe_req_t push_data,
  output logic       pop_valid,
  input  logic       pop_ready,
  output probe_req_t pop_data
);

  probe_req_t          entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic                do_push;
  logic                do_pop;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] n;
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) n = '0;
    else                               n = p + 1'b1;
    return n;
  endfunction

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = entries_r[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* hdl/lph_back.sv */
module lph_back import lph_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    req_valid,
  output logic                    req_ready,
  input  probe_req_t              req,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [STATUS_W-1:0]     out_status,
  output logic [SLOT_FIELD_W-1:0] out_slot
);

  typedef enum logic [2:0] {
    BS_CLEAR = 3'b001,
    BS_IDLE  = 3'b010,
    BS_PROBE = 3'b100
  } back_state_t;

  back_state_t state_r, state_nxt;
  slot_t       s_r, s_nxt;
  slot_t       n_r, n_nxt;
  op_t         op_r;
  key_t        key_r;
  logic        out_valid_r;
  status_t     out_status_r;
  logic [SLOT_FIELD_W-1:0] out_slot_r;

  logic              wr_en;
  slot_t             wr_addr;
  logic [KEY_W:0]    wr_data;
  slot_t             rd_addr;
  logic [KEY_W:0]    rd_data;

  logic     entry_used;
  key_t     entry_key;
  logic     last;
  logic     out_free;
  logic     decide;
  logic     write_slot;
  logic     commit;
  logic     advance;
  logic     pop;
  status_t  res_status;
  slot_t    res_slot;

  // Slot store: {used, key} per slot
  lph_ram #(
    .WIDTH (KEY_W + 1),
    .DEPTH (TABLE_SLOTS)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign entry_used = rd_data[KEY_W];
  assign entry_key  = rd_data[KEY_W-1:0];
  assign last       = (n_r == SLOT_W'(TABLE_SLOTS - 1));
  assign out_free   = !out_valid_r || out_ready;

  // Probe decision for the slot whose data is on the read port
  always_comb begin
    decide     = 1'b0;
    write_slot = 1'b0;
    res_status = ST_OK;
    res_slot   = s_r;
    if (state_r == BS_PROBE) begin
      if (op_r == OP_INSERT) begin
        if (!entry_used) begin
          decide     = 1'b1;
          write_slot = 1'b1;
        end else if (last) begin
          decide     = 1'b1;
          res_status = ST_FULL;
          res_slot   = '0;
        end
      end else begin
        if (!entry_used) begin
          decide     = 1'b1;
          res_status = ST_NOT_FOUND;
          res_slot   = '0;
        end else if (entry_key == key_r) begin
          decide     = 1'b1;
        end else if (last) begin
          decide     = 1'b1;
          res_status = ST_NOT_FOUND;
          res_slot   = '0;
        end
      end
    end
  end

  assign commit    = decide && out_free;
  assign advance   = (state_r == BS_PROBE) && !decide;
  assign pop       = (state_r == BS_IDLE) && req_valid;
  assign req_ready = pop;

  // Memory ports and next state
  always_comb begin
    state_nxt = state_r;
    s_nxt     = s_r;
    n_nxt     = n_r;
    wr_en     = 1'b0;
    wr_addr   = s_r;
    wr_data   = '0;
    rd_addr   = s_r;
    case (state_r)
      BS_CLEAR: begin
        wr_en = 1'b1;
        s_nxt = next_slot(s_r);
        if (s_r == SLOT_W'(TABLE_SLOTS - 1)) begin
          state_nxt = BS_IDLE;
          s_nxt     = '0;
        end
      end
      BS_IDLE: begin
        rd_addr = req.home;
        if (pop) begin
          state_nxt = BS_PROBE;
          s_nxt     = req.home;
          n_nxt     = '0;
        end
      end
      BS_PROBE: begin
        wr_en   = commit && write_slot;
        wr_data = {1'b1, key_r};
        if (advance) begin
          rd_addr = next_slot(s_r);
          s_nxt   = next_slot(s_r);
          n_nxt   = n_r + 1'b1;
        end
        if (commit) begin
          state_nxt = BS_IDLE;
        end
      end
      default: begin
        state_nxt = BS_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_CLEAR;
      s_r         <= '0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      s_r     <= s_nxt;
      n_r     <= n_nxt;
      if (commit)         out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      op_r  <= req.op;
      key_r <= req.key;
    end
    if (commit) begin
      out_status_r <= res_status;
      out_slot_r   <= SLOT_FIELD_W'(res_slot);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;

`ifndef NO_ASSERTIONS
  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BS_CLEAR) |-> !req_ready)
    else $error("request taken during clearing pass");

  a_full_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && res_status == ST_FULL) |-> (op_r == OP_INSERT && last))
    else $error("full status without a complete insert probe");

  a_write_gives_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && state_r == BS_PROBE) |=>
      (state_r == BS_IDLE && out_valid_r && out_status_r == ST_OK))
    else $error("slot write without an ok result");

  a_pop_starts_home: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (state_r == BS_PROBE && s_r == $past(req.home) && n_r == '0))
    else $error("probe does not start at home slot");
`endif

endmodule

/* hdl/linear_probe_hash_table.sv */
// The front registers each input beat with its home slot, the queue holds it,
// and the back reads the home slot and probes slot after slot until it
// decides, then registers the result; a non-power-of-two table size adds the
// digit-serial home slot remainder, 4 key bits a step. The back handles one
// beat at a time. Reset clears all control state, then a clearing pass over all
// TABLE_SLOTS slots empties the slot memory; input beats are queued meanwhile.
module linear_probe_hash_table import lph_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_opcode,
  input  logic [KEY_W-1:0]        in_key,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [STATUS_W-1:0]     out_status,
  output logic [SLOT_FIELD_W-1:0] out_slot
);

  logic       fq_valid;
  logic       fq_ready;
  probe_req_t fq_data;
  logic       qb_valid;
  logic       qb_ready;
  probe_req_t qb_data;

  // Front: accept and compute home slot
  lph_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .in_key    (in_key),
    .req_valid (fq_valid),
    .req_ready (fq_ready),
    .req       (fq_data)
  );

  // Decoupling queue
  lph_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  // Back: probe engine and result register
  lph_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (qb_valid),
    .req_ready  (qb_ready),
    .req        (qb_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_slot   (out_slot)
  );

endmodule
